FILE: hdl/sdr_pkg.sv
package sdr_pkg;

  localparam int unsigned MAX_DICE      = 255;
  localparam int unsigned PERCENT_SIDES = 100;

  localparam logic [63:0] GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_B = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 64;

  localparam logic REG_SEED = 1'b0;

  localparam logic OP_ROLL    = 1'b0;
  localparam logic OP_PERCENT = 1'b1;

endpackage

FILE: hdl/splitmix_dice_roller.sv
// Dice roller on a splitmix64 generator.
// Request words enter on the s_axis channel: tuser carries the request kind
// (roll and sum dice, or percent check), tdata carries count, sides, chance.
// Each result word leaves on the m_axis channel: total and hit in tdata.
// The seed register sits at APB address 0 and its aliases 1 to 7 (only
// paddr bit 3 is decoded); a write also reloads the generator state.
// Reads return the seed there; addresses 8 and up read as zero.
// A request that needs no draw (zero dice, dice with 0 or 1 sides, chance
// 0 or 100 and up) goes straight to ST_DONE. Every die drawn runs one
// add and xor-shift, two 64-bit multiplies of three 32x32 partial
// products each on the single shared multiplier, one xor-shift and one
// scaling multiply. ST_DONE loads the output register and the sequencer
// returns to idle; no new request is taken while dice are being drawn.
// s_axis_tready_o is high only while the sequencer is idle; the result sits
// in an output register, so a new request is taken while the previous word
// waits. If the receiver stalls past the end of the next request, the
// sequencer holds it until the output register frees up.
// Reset clears the seed to 0, loads the generator with it and drops any
// pending result.
module splitmix_dice_roller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // die_count [7:0], die_sides [39:8], chance [47:40]
  input  logic [sdr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // opcode [0]
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // total [31:0], hit [32], zero [39:33]
  output logic [sdr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [sdr_pkg::APB_ADDR_W-1:0]    paddr_i,
  input  logic [sdr_pkg::APB_DATA_W-1:0]    pwdata_i,
  output logic [sdr_pkg::APB_DATA_W-1:0]    prdata_o,
  output logic                              pready_o
);
  import sdr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_LL,
    ST_LH,
    ST_HL,
    ST_XOR,
    ST_DIE,
    ST_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] gen_q, gen_d;
  logic [63:0] z_q, z_d;
  logic [63:0] acc_q, acc_d;
  logic        round_q, round_d;
  logic        op_q, op_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] sides_q, sides_d;
  logic [7:0]  chance_q, chance_d;
  logic [31:0] total_q, total_d;
  logic        hit_q, hit_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_total_q, out_total_d;
  logic        out_hit_q, out_hit_d;

  logic [63:0] mix_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] draw_x;
  logic [31:0] roll;
  logic [7:0]  in_count;
  logic [31:0] in_sides;
  logic [7:0]  in_chance;
  logic        cfg_wr;

  assign in_count  = s_axis_tdata_i[7:0];
  assign in_sides  = s_axis_tdata_i[39:8];
  assign in_chance = s_axis_tdata_i[47:40];

  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[3] == REG_SEED) ? seed_q : '0;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_hit_q, out_total_q};

  assign mix_k  = round_q ? MIX_B : MIX_A;
  assign draw_x = acc_q[63:32] ^ {31'b0, acc_q[63]};
  assign roll   = 32'd1 + mul_p[63:32];

  always_comb begin
    unique case (state_q)
      ST_LH: begin
        mul_a = z_q[31:0];
        mul_b = mix_k[63:32];
      end
      ST_HL: begin
        mul_a = z_q[63:32];
        mul_b = mix_k[31:0];
      end
      ST_DIE: begin
        mul_a = draw_x;
        mul_b = sides_q;
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mix_k[31:0];
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    gen_d       = gen_q;
    z_d         = z_q;
    acc_d       = acc_q;
    round_d     = round_q;
    op_d        = op_q;
    count_d     = count_q;
    sides_d     = sides_q;
    chance_d    = chance_q;
    total_d     = total_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_total_d = out_total_q;
    out_hit_d   = out_hit_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = s_axis_tuser_i;
          chance_d = in_chance;
          total_d  = '0;
          hit_d    = 1'b0;
          if (s_axis_tuser_i == OP_ROLL) begin
            count_d = (32'(in_count) > MAX_DICE) ? 8'(MAX_DICE) : in_count;
            sides_d = in_sides;
            if (in_count == 8'd0 || in_sides == 32'd0) begin
              state_d = ST_DONE;
            end else if (in_sides == 32'd1) begin
              total_d = 32'(count_d);
              state_d = ST_DONE;
            end else begin
              state_d = ST_ADD;
            end
          end else begin
            count_d = 8'd1;
            sides_d = 32'(PERCENT_SIDES);
            if (in_chance == 8'd0) begin
              state_d = ST_DONE;
            end else if (32'(in_chance) >= PERCENT_SIDES) begin
              hit_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              state_d = ST_ADD;
            end
          end
        end
      end
      ST_ADD: begin
        gen_d   = gen_q + GAMMA;
        z_d     = gen_d ^ (gen_d >> 30);
        round_d = 1'b0;
        state_d = ST_LL;
      end
      ST_LL: begin
        acc_d   = mul_p;
        state_d = ST_LH;
      end
      ST_LH: begin
        acc_d   = acc_q + {mul_p[31:0], 32'b0};
        state_d = ST_HL;
      end
      ST_HL: begin
        acc_d   = acc_q + {mul_p[31:0], 32'b0};
        state_d = round_q ? ST_DIE : ST_XOR;
      end
      ST_XOR: begin
        z_d     = acc_q ^ (acc_q >> 27);
        round_d = 1'b1;
        state_d = ST_LL;
      end
      ST_DIE: begin
        if (op_q == OP_PERCENT) begin
          hit_d   = (roll <= 32'(chance_q));
          state_d = ST_DONE;
        end else begin
          total_d = total_q + roll;
          count_d = count_q - 8'd1;
          state_d = (count_q == 8'd1) ? ST_DONE : ST_ADD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          out_hit_d   = hit_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_wr && paddr_i[3] == REG_SEED) begin
      seed_d = pwdata_i;
      gen_d  = pwdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      gen_q       <= '0;
      z_q         <= '0;
      acc_q       <= '0;
      round_q     <= 1'b0;
      op_q        <= 1'b0;
      count_q     <= '0;
      sides_q     <= '0;
      chance_q    <= '0;
      total_q     <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_total_q <= '0;
      out_hit_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      gen_q       <= gen_d;
      z_q         <= z_d;
      acc_q       <= acc_d;
      round_q     <= round_d;
      op_q        <= op_d;
      count_q     <= count_d;
      sides_q     <= sides_d;
      chance_q    <= chance_d;
      total_q     <= total_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      out_total_q <= out_total_d;
      out_hit_q   <= out_hit_d;
    end
  end

endmodule

FILE: dv/tb_splitmix_dice_roller.sv
module tb_splitmix_dice_roller;
  timeunit 1ns;
  timeprecision 1ps;

  import sdr_pkg::*;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned HOLDOFF_CYCLES = 4000;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 40;

  localparam logic [APB_ADDR_W-1:0] SEED_ADDR  = {REG_SEED, 3'b000};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 4'h8;

  typedef struct {
    logic        op;
    logic [7:0]  count;
    logic [31:0] sides;
    logic [7:0]  chance;
  } dice_request_t;

  typedef struct {
    logic [31:0] total;
    logic        hit;
  } dice_result_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr     = '0;
  logic [APB_DATA_W-1:0]  pwdata    = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  dice_request_t queued_requests[$];
  dice_result_t  expected_rolls[$];

  logic [63:0] seed_shadow = '0;
  logic [63:0] gen_shadow  = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned holdoff_seq     = 0;
  int unsigned holdoff_seen    = 0;
  int unsigned holdoff_left    = 0;
  int unsigned stuck_cycles    = 0;
  int unsigned mismatches      = 0;

  splitmix_dice_roller i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic logic [63:0] splitmix_next();
    logic [63:0] z;
    gen_shadow = gen_shadow + GAMMA;
    z = gen_shadow;
    z = (z ^ (z >> 30)) * MIX_A;
    z = (z ^ (z >> 27)) * MIX_B;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [31:0] die_face(logic [31:0] sides);
    logic [63:0] x;
    logic [63:0] prod;
    if (sides <= 32'd1) begin
      return sides;
    end
    x = splitmix_next() >> 32;
    prod = x * {32'h0, sides};
    return prod[63:32] + 32'd1;
  endfunction

  function automatic dice_result_t roll_outcome(dice_request_t req);
    dice_result_t res;
    int unsigned  n;
    res.total = '0;
    res.hit   = 1'b0;
    if (req.op == OP_ROLL) begin
      n = (req.count > MAX_DICE) ? MAX_DICE : req.count;
      for (int unsigned i = 0; i < n; i++) begin
        res.total = res.total + die_face(req.sides);
      end
    end else if (req.chance == 8'd0) begin
      res.hit = 1'b0;
    end else if (req.chance >= PERCENT_SIDES) begin
      res.hit = 1'b1;
    end else begin
      res.hit = (die_face(PERCENT_SIDES) <= {24'h0, req.chance});
    end
    return res;
  endfunction

  function automatic dice_request_t random_request();
    dice_request_t req;
    int unsigned   pick;
    req.op = 1'($urandom_range(1, 0));
    pick = $urandom_range(99);
    if (pick < 85) begin
      req.count = 8'($urandom_range(8, 0));
    end else if (pick < 97) begin
      req.count = 8'($urandom_range(64, 9));
    end else begin
      req.count = 8'($urandom_range(255, 65));
    end
    pick = $urandom_range(99);
    if (pick < 15) begin
      req.sides = $urandom_range(1, 0);
    end else if (pick < 55) begin
      req.sides = $urandom_range(20, 2);
    end else begin
      req.sides = $urandom;
    end
    req.chance = ($urandom_range(1, 0) != 0) ? 8'($urandom_range(110, 0))
                                             : 8'($urandom_range(255, 0));
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_request(logic op, logic [7:0] count, logic [31:0] sides,
                               logic [7:0] chance);
    dice_request_t req;
    req.op     = op;
    req.count  = count;
    req.sides  = sides;
    req.chance = chance;
    queued_requests.push_back(req);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && addr == SEED_ADDR) begin
      seed_shadow = data;
      gen_shadow  = data;
    end
    @(negedge clk_i);
  endtask

  task automatic check_seed_readback();
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, SEED_ADDR, '0, rdata);
    if (rdata !== seed_shadow) begin
      report_mismatch("seed readback", rdata, seed_shadow);
    end
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || expected_rolls.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_phase(input logic [63:0] seed, input int unsigned items,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit holdoff);
    logic [APB_DATA_W-1:0] rdata;
    @(negedge clk_i);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    apb_access(1'b1, SEED_ADDR, seed, rdata);
    check_seed_readback();
    if (holdoff) begin
      holdoff_seq++;
    end
    repeat (items) queued_requests.push_back(random_request());
    wait_drained();
  endtask

  always @(posedge clk_i) begin : drive_requests
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_rolls.push_back(roll_outcome(queued_requests[0]));
        queued_requests.delete(0);
      end
      if (!s_tvalid || s_tready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {queued_requests[0].chance, queued_requests[0].sides,
                       queued_requests[0].count};
          s_tuser  <= queued_requests[0].op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : receiver_holdoff
    if (holdoff_seq != holdoff_seen) begin
      holdoff_seen <= holdoff_seq;
      holdoff_left <= HOLDOFF_CYCLES;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk_i) begin : watch_results
    dice_result_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_rolls.size() == 0) begin
          report_mismatch("unexpected result word", 64'(m_tdata), '0);
        end else begin
          want = expected_rolls[0];
          expected_rolls.delete(0);
          if (m_tdata[31:0] !== want.total) begin
            report_mismatch("total", 64'(m_tdata[31:0]), 64'(want.total));
          end
          if (m_tdata[32] !== want.hit) begin
            report_mismatch("hit", 64'(m_tdata[32]), 64'(want.hit));
          end
          if (m_tdata[39:33] !== 7'h0) begin
            report_mismatch("pad bits", 64'(m_tdata[39:33]), '0);
          end
        end
      end
      if (holdoff_left != 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_splitmix_dice_roller failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [APB_DATA_W-1:0] rdata;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset seed, degenerate dice, zero dice, wrap, every percent edge
    check_seed_readback();
    queue_request(OP_ROLL, 8'd0, 32'd6, 8'd0);
    queue_request(OP_ROLL, 8'd1, 32'd0, 8'd0);
    queue_request(OP_ROLL, 8'd3, 32'd1, 8'd0);
    queue_request(OP_ROLL, 8'd255, 32'd0, 8'd255);
    queue_request(OP_ROLL, 8'd255, 32'd1, 8'd0);
    queue_request(OP_ROLL, 8'd1, 32'd2, 8'd0);
    queue_request(OP_ROLL, 8'd6, 32'd6, 8'd50);
    queue_request(OP_ROLL, 8'd1, 32'hFFFF_FFFF, 8'd0);
    queue_request(OP_ROLL, 8'd2, 32'h8000_0000, 8'd0);
    queue_request(OP_ROLL, 8'd255, 32'hFFFF_FFFF, 8'd0);
    queue_request(OP_PERCENT, 8'd0, 32'd0, 8'd0);
    queue_request(OP_PERCENT, 8'd255, 32'hFFFF_FFFF, 8'd0);
    queue_request(OP_PERCENT, 8'd0, 32'd0, 8'd1);
    queue_request(OP_PERCENT, 8'd0, 32'd0, 8'd50);
    queue_request(OP_PERCENT, 8'd0, 32'd0, 8'd99);
    queue_request(OP_PERCENT, 8'd0, 32'd0, 8'd100);
    queue_request(OP_PERCENT, 8'd0, 32'd0, 8'd101);
    queue_request(OP_PERCENT, 8'd7, 32'd9, 8'd255);
    wait_drained();

    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 340, 0, 0, 1'b0);
    run_phase(64'h0, 340, 69, 0, 1'b0);

    // drop the write to an unmapped register
    apb_access(1'b1, SPARE_ADDR, {$urandom, $urandom}, rdata);
    check_seed_readback();

    run_phase({$urandom, $urandom}, 340, 0, 69, 1'b0);
    run_phase(64'h8000_0000_0000_0000, 320, 22, 22, 1'b0);
    run_phase({$urandom, $urandom}, 30, 0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_rolls.size() != 0) begin
      report_mismatch("results left over", 64'(expected_rolls.size()), '0);
    end
    if (mismatches == 0) begin
      $display("tb_splitmix_dice_roller passed");
    end else begin
      $display("tb_splitmix_dice_roller failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sdr_pkg.sv
hdl/splitmix_dice_roller.sv
dv/tb_splitmix_dice_roller.sv
